[src/mmkc_pkg.sv]
// Shared types and constants for the memory map kernel carve block.
`timescale 1ns / 1ps
package mmkc_pkg;

	localparam int ADDR_BITS = 64;
	localparam int FIELD_W   = 64;
	localparam int TYPE_W    = 32;
	localparam int TAG_W     = 2;
	localparam int PADDR_W   = 5;

	localparam logic [TAG_W-1:0] TAG_FW       = 2'd0;
	localparam logic [TAG_W-1:0] TAG_KERNEL   = 2'd1;
	localparam logic [TAG_W-1:0] TAG_RESERVED = 2'd2;

	localparam logic [1:0] REG_KSTART = 2'd0;
	localparam logic [1:0] REG_KEND   = 2'd1;
	localparam logic [1:0] REG_LLIM   = 2'd2;

	localparam logic [FIELD_W-1:0] LOW_LIMIT_RST = 64'd1048576;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef struct packed {
		addr_t addr;
		addr_t len;
		logic  kern;
	} piece_t;

endpackage

[src/memory_map_kernel_carve.sv]
// Top level: carves the kernel range out of a stream of memory map regions.
`timescale 1ns / 1ps
// Each accepted region is split into up to three pieces (head before the kernel, the
// kernel region, tail after it) held in the carve register; the pieces then leave one
// per cycle through the result register while result_ready allows, where the low-limit
// correction is applied in order. A region holds the carve register until its last
// piece moves out, or until it retires when it yields none; the block takes a new
// region in that same cycle. Results pass through the carve register and then the
// result register. Registers sit on the APB port at byte addresses 0, 8 and 16
// (kernel start, kernel end, low limit); write them only while the block is idle.
module memory_map_kernel_carve import mmkc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [FIELD_W-1:0]   pwdata,
	output logic [FIELD_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 region_valid,
	output logic                 region_ready,
	input  logic [FIELD_W-1:0]   region_addr,
	input  logic [FIELD_W-1:0]   region_len,
	input  logic [TYPE_W-1:0]    region_type,
	input  logic                 new_map,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [FIELD_W-1:0]   out_addr,
	output logic [FIELD_W-1:0]   out_len,
	output logic [TYPE_W-1:0]    out_type,
	output logic [TAG_W-1:0]     out_tag,
	output logic                 out_last
);

	logic [FIELD_W-1:0] kstart_q, kend_q, llim_q;
	addr_t ks, ke, lim;

	logic inside_q, emitted_q, lfd_q;

	// carve stage
	logic          valid_s1, first_s1, new_map_s1;
	logic [2:0]    mask_s1;
	piece_t        pc_s1 [3];
	logic [TYPE_W-1:0] type_s1;

	logic [FIELD_W-1:0] out_addr_q, out_len_q;
	logic [TYPE_W-1:0]  out_type_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               out_last_q, result_valid_q;

	assign ks  = kstart_q[ADDR_BITS-1:0];
	assign ke  = kend_q[ADDR_BITS-1:0];
	assign lim = llim_q[ADDR_BITS-1:0];

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kstart_q <= '0;
			kend_q   <= '0;
			llim_q   <= LOW_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:3])
				REG_KSTART: kstart_q <= pwdata;
				REG_KEND:   kend_q   <= pwdata;
				REG_LLIM:   llim_q   <= pwdata;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_KSTART: prdata = kstart_q;
			REG_KEND:   prdata = kend_q;
			REG_LLIM:   prdata = llim_q;
			default:    prdata = '0;
		endcase
	end

	// carve one region into pieces
	addr_t  a_in, l_in, last_in, tail_start, tail_len;
	logic   ik, ea, outside, ik_next, acc_in;
	piece_t p0, p1, p2;
	logic [2:0] m_in;

	assign a_in    = region_addr[ADDR_BITS-1:0];
	assign l_in    = region_len[ADDR_BITS-1:0];
	assign last_in = a_in + l_in - ADDR_BITS'(1);
	assign ik      = inside_q && !new_map;
	assign ea      = emitted_q && !new_map;
	assign outside = (last_in < ks) || (a_in >= ke);
	// last - start + 1 without waiting on last
	assign tail_start = (a_in > ke) ? a_in : ke;
	assign tail_len   = (a_in > ke) ? l_in : a_in + l_in - ke;
	assign acc_in     = region_valid && region_ready;

	always_comb begin
		p0      = '{addr: ks, len: ke - ks, kern: 1'b1};
		p1      = '{addr: a_in, len: l_in, kern: 1'b0};
		p2      = '{addr: tail_start, len: tail_len, kern: 1'b0};
		m_in    = 3'b000;
		ik_next = ik;
		if (!ik) begin
			if (outside) begin
				// kernel goes first when the map starts above it
				m_in[0] = !ea && (a_in >= ke);
				m_in[1] = 1'b1;
			end else begin
				p0      = '{addr: a_in, len: ks - a_in, kern: 1'b0};
				m_in[0] = a_in < ks;
				p1      = '{addr: ks, len: ke - ks, kern: 1'b1};
				m_in[1] = 1'b1;
				m_in[2] = last_in >= ke;
				ik_next = !(last_in >= ke);
			end
		end else if (last_in >= ke) begin
			m_in[2] = 1'b1;
			ik_next = 1'b0;
		end
	end

	// pick the next piece and apply the low-limit fix
	piece_t     cur;
	logic [2:0] rest;
	logic       out_load, retire, eff_lfd, fix_lfd;
	addr_t      fix_addr, fix_len;
	logic [TAG_W-1:0] fix_tag;

	always_comb begin
		if (mask_s1[0]) begin
			cur  = pc_s1[0];
			rest = {mask_s1[2:1], 1'b0};
		end else if (mask_s1[1]) begin
			cur  = pc_s1[1];
			rest = {mask_s1[2], 2'b00};
		end else begin
			cur  = pc_s1[2];
			rest = 3'b000;
		end
	end

	assign out_load = valid_s1 && (mask_s1 != 3'b000) && (!result_valid_q || result_ready);
	assign retire   = valid_s1 && ((mask_s1 == 3'b000) || (out_load && rest == 3'b000));
	assign region_ready = !valid_s1 || retire;
	assign eff_lfd  = lfd_q && !(new_map_s1 && first_s1);

	always_comb begin
		fix_addr = cur.addr;
		fix_len  = cur.len;
		fix_tag  = cur.kern ? TAG_KERNEL : TAG_FW;
		fix_lfd  = eff_lfd;
		if (!eff_lfd) begin
			if (cur.addr >= lim) begin
				fix_lfd = 1'b1;
			end else if (cur.len > lim - cur.addr) begin
				// straddles the limit: trim to start at it
				fix_len  = cur.len + cur.addr - lim;
				fix_addr = lim;
				fix_lfd  = 1'b1;
			end else begin
				fix_tag = TAG_RESERVED;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			emitted_q  <= 1'b0;
			lfd_q      <= 1'b0;
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			new_map_s1 <= 1'b0;
			mask_s1    <= 3'b000;
			result_valid_q <= 1'b0;
		end else begin
			if (acc_in) begin
				inside_q  <= ik_next;
				emitted_q <= ea || (m_in != 3'b000);
			end
			if (out_load) begin
				lfd_q <= fix_lfd;
			end else if (retire && new_map_s1 && first_s1) begin
				lfd_q <= 1'b0;
			end
			if (acc_in) begin
				valid_s1   <= 1'b1;
				first_s1   <= 1'b1;
				new_map_s1 <= new_map;
				mask_s1    <= m_in;
			end else if (retire) begin
				valid_s1 <= 1'b0;
				mask_s1  <= 3'b000;
			end else if (out_load) begin
				mask_s1  <= rest;
				first_s1 <= 1'b0;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc_in) begin
			pc_s1[0] <= p0;
			pc_s1[1] <= p1;
			pc_s1[2] <= p2;
			type_s1  <= region_type;
		end
		if (out_load) begin
			out_addr_q <= FIELD_W'(fix_addr);
			out_len_q  <= FIELD_W'(fix_len);
			out_type_q <= type_s1;
			out_tag_q  <= fix_tag;
			out_last_q <= rest == 3'b000;
		end
	end

	assign result_valid = result_valid_q;
	assign out_addr     = out_addr_q;
	assign out_len      = out_len_q;
	assign out_type     = out_type_q;
	assign out_tag      = out_tag_q;
	assign out_last     = out_last_q;

	// a non-final beat is always followed by the next piece
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !out_last |=> result_valid)
		else $error("piece missing after non-final beat");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> region_ready)
		else $error("carve stage empty but region not ready");

	a_lfd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(lfd_q) |-> $past(valid_s1 && new_map_s1 && first_s1))
		else $error("low-limit flag cleared outside a new map");

	a_tag_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (out_tag == TAG_FW || out_tag == TAG_KERNEL ||
			out_tag == TAG_RESERVED))
		else $error("bad result tag");

endmodule

[bench/mmkc_checker.sv]
// Checker for the kernel carve block: tracks config writes, predicts carved regions, compares.
`timescale 1ns / 1ps
module mmkc_checker import mmkc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [FIELD_W-1:0] pwdata,
	input  logic               region_valid,
	input  logic               region_ready,
	input  logic [FIELD_W-1:0] region_addr,
	input  logic [FIELD_W-1:0] region_len,
	input  logic [TYPE_W-1:0]  region_type,
	input  logic               new_map,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [FIELD_W-1:0] out_addr,
	input  logic [FIELD_W-1:0] out_len,
	input  logic [TYPE_W-1:0]  out_type,
	input  logic [TAG_W-1:0]   out_tag,
	input  logic               out_last,
	output int                 miss_count,
	output int                 pieces_due
);

	typedef struct packed {
		addr_t             addr;
		addr_t             len;
		logic [TYPE_W-1:0] rtype;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} carved_t;

	carved_t carved_q[$];
	carved_t cut[3];
	int      n_cut;
	int      fails;

	addr_t k_start, k_end, low_lim;
	logic  kern_open, any_out, limit_done;

	// one emitted piece, with the low-limit retag/trim applied in emission order
	task automatic add_piece(input addr_t a, input addr_t l, input logic [TYPE_W-1:0] ty,
			input logic [TAG_W-1:0] tg);
		if (!limit_done) begin
			if (a >= low_lim) begin
				limit_done = 1'b1;
			end else if (l > low_lim - a) begin
				l = l - (low_lim - a);
				a = low_lim;
				limit_done = 1'b1;
			end else begin
				tg = TAG_RESERVED;
			end
		end
		cut[n_cut] = '{addr: a, len: l, rtype: ty, tag: tg, last: 1'b0};
		n_cut++;
		any_out = 1'b1;
	endtask

	task automatic carve_region(input addr_t a, input addr_t l, input logic [TYPE_W-1:0] ty,
			input logic nm);
		addr_t last_b;
		addr_t start;
		last_b = a + l - 1;
		n_cut = 0;
		if (nm) begin
			kern_open = 1'b0;
			any_out = 1'b0;
			limit_done = 1'b0;
		end
		if (!kern_open) begin
			if (last_b < k_start || a >= k_end) begin
				// kernel goes out ahead of a first region lying above it
				if (!any_out && a >= k_end)
					add_piece(k_start, k_end - k_start, ty, TAG_KERNEL);
				add_piece(a, l, ty, TAG_FW);
			end else begin
				if (a < k_start)
					add_piece(a, k_start - a, ty, TAG_FW);
				add_piece(k_start, k_end - k_start, ty, TAG_KERNEL);
				kern_open = 1'b1;
				if (last_b >= k_end) begin
					add_piece(k_end, last_b - k_end + 1, ty, TAG_FW);
					kern_open = 1'b0;
				end
			end
		end else if (last_b >= k_end) begin
			start = (a > k_end) ? a : k_end;
			add_piece(start, last_b - start + 1, ty, TAG_FW);
			kern_open = 1'b0;
		end
		if (n_cut > 0)
			cut[n_cut-1].last = 1'b1;
		for (int i = 0; i < n_cut; i++)
			carved_q.push_back(cut[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		carved_t want;
		if (!arst_n) begin
			k_start = '0;
			k_end = '0;
			low_lim = LOW_LIMIT_RST;
			kern_open = 1'b0;
			any_out = 1'b0;
			limit_done = 1'b0;
			carved_q.delete();
			fails = 0;
			miss_count <= 0;
			pieces_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:3])
					REG_KSTART: k_start = pwdata;
					REG_KEND:   k_end = pwdata;
					REG_LLIM:   low_lim = pwdata;
					default: ;
				endcase
			end
			if (region_valid && region_ready)
				carve_region(region_addr, region_len, region_type, new_map);
			if (result_valid && result_ready) begin
				if (carved_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t: unexpected beat addr=%h len=%h type=%h tag=%0d last=%0d",
							$realtime, out_addr, out_len, out_type, out_tag, out_last);
				end else begin
					want = carved_q.pop_front();
					if (want.addr !== out_addr || want.len !== out_len || want.rtype !== out_type
							|| want.tag !== out_tag || want.last !== out_last) begin
						fails++;
						if (fails <= 10)
							$display({"%t: mismatch exp addr=%h len=%h type=%h tag=%0d last=%0d",
								" got addr=%h len=%h type=%h tag=%0d last=%0d"}, $realtime,
								want.addr, want.len, want.rtype, want.tag, want.last,
								out_addr, out_len, out_type, out_tag, out_last);
					end
				end
			end
			miss_count <= fails;
			pieces_due <= carved_q.size();
		end
	end

endmodule

[bench/tb_memory_map_kernel_carve.sv]
// Testbench top for the kernel carve block: stimulus, APB setup, flow control and verdict.
`timescale 1ns / 1ps
module tb_memory_map_kernel_carve;
	import mmkc_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [FIELD_W-1:0] pwdata, prdata;
	logic               region_valid, region_ready;
	logic [FIELD_W-1:0] region_addr, region_len;
	logic [TYPE_W-1:0]  region_type;
	logic               new_map;
	logic               result_valid, result_ready;
	logic [FIELD_W-1:0] out_addr, out_len;
	logic [TYPE_W-1:0]  out_type;
	logic [TAG_W-1:0]   out_tag;
	logic               out_last;

	int miss_count, pieces_due;
	int burst_left;
	int choke_req, choke_done;
	int idle_cycles;

	memory_map_kernel_carve uut (.*);

	mmkc_checker carve_chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata),
		.region_valid(region_valid), .region_ready(region_ready),
		.region_addr(region_addr), .region_len(region_len), .region_type(region_type),
		.new_map(new_map), .result_valid(result_valid), .result_ready(result_ready),
		.out_addr(out_addr), .out_len(out_len), .out_type(out_type), .out_tag(out_tag),
		.out_last(out_last), .miss_count(miss_count), .pieces_due(pieces_due)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic addr_t rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic reg_write(input logic [1:0] idx, input addr_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_region(input addr_t a, input addr_t l, input logic [TYPE_W-1:0] ty,
			input logic nm);
		region_valid <= 1'b1;
		region_addr <= a;
		region_len <= l;
		region_type <= ty;
		new_map <= nm;
		@(posedge clk);
		while (!region_ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			region_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	// stop offering, let every piece drain, then reprogram the kernel range and limit
	task automatic set_carve(input addr_t ks, input addr_t ke, input addr_t ll);
		region_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pieces_due != 0)
			@(posedge clk);
		// a region yielding nothing may still sit in the carve stage
		repeat (4) @(posedge clk);
		reg_write(REG_KSTART, ks);
		reg_write(REG_KEND, ke);
		reg_write(REG_LLIM, ll);
	endtask

	// receiver: changing stall patterns, plus long hold-offs on request
	initial begin : rx_side
		int rx_mode;
		int rx_left;
		rx_mode = 0;
		rx_left = 20;
		choke_done = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (choke_done != choke_req) begin
				choke_done = choke_req;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				case (rx_mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= ($urandom_range(0, 3) == 0);
					default: result_ready <= ($urandom_range(0, 7) == 0);
				endcase
				rx_left--;
				if (rx_left <= 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(5, 60);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (region_valid && region_ready) || (result_valid && result_ready)
				|| (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[memory_map_kernel_carve] ERROR");
			$finish;
		end
	end

	initial begin : stim
		addr_t unit, ks, ke, ll, cur, len;
		logic  nm;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		region_valid = 1'b0;
		region_addr = '0;
		region_len = '0;
		region_type = '0;
		new_map = 1'b0;
		choke_req = 0;
		burst_left = 4;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a typical map around a 2M..4M kernel
		set_carve(64'h20_0000, 64'h40_0000, 64'h10_0000);
		send_region(64'h0, 64'h9_F000, 32'd1, 1'b1);          // wholly below limit
		send_region(64'h9_F000, 64'h8_0000, 32'd2, 1'b0);     // straddles the limit
		send_region(64'h12_0000, 64'h4E_0000, 32'd1, 1'b0);   // head, kernel, tail
		send_region(64'h70_0000, 64'h10_0000, 32'd3, 1'b0);
		send_region(64'h21_0000, 64'h10_0000, 32'd1, 1'b1);   // starts inside kernel
		send_region(64'h31_0000, 64'h1_0000, 32'd4, 1'b0);    // ends inside: nothing out
		send_region(64'h32_0000, 64'h20_0000, 32'd1, 1'b0);
		send_region(64'h80_0000, 64'h1000, 32'd5, 1'b1);      // first region above kernel
		send_region(64'h0, 64'h10_0000, 32'd1, 1'b1);
		send_region(64'h50_0000, 64'h10_0000, 32'd1, 1'b0);   // kernel sits in a hole
		send_region(64'h0, 64'h0, 32'd0, 1'b1);               // zero length
		send_region('1, '1, '1, 1'b1);
		send_region(64'h0, '1, 32'h5A5A_5A5A, 1'b0);

		// reversed kernel bounds, no limit
		set_carve(64'h40_0000, 64'h20_0000, 64'h0);
		send_region(64'h10_0000, 64'h40_0000, 32'd1, 1'b1);
		send_region(64'h50_0000, 64'h1000, 32'd2, 1'b0);
		send_region(64'h30_0000, 64'h10, 32'd7, 1'b1);

		set_carve(64'h0, '1, '1);
		send_region(64'h0, 64'h1000, 32'd1, 1'b1);
		send_region(64'h1000, '1, 32'd2, 1'b0);
		send_region('1, 64'h1, 32'd3, 1'b0);

		set_carve('1, 64'h0, 64'h100);
		send_region(64'h80, 64'h100, 32'd1, 1'b1);
		send_region('1, 64'h1, 32'hFFFF_0000, 1'b0);

		// random maps: mostly ordered regions near the kernel scale, some noise
		for (int p = 0; p < 8; p++) begin
			unit = 64'd1 << $urandom_range(4, 36);
			ks = unit * $urandom_range(0, 12);
			ke = ks + unit * $urandom_range(0, 8);
			ll = unit * $urandom_range(0, 10);
			case (p)
				0: ll = '0;
				1: ll = '1;
				2: begin
					ks = '0;
					ke = '1;
				end
				3: ke = ks - unit;
				default: ;
			endcase
			set_carve(ks, ke, ll);
			if (p == 1 || p == 5)
				choke_req++;
			cur = unit * $urandom_range(0, 3);
			nm = 1'b1;
			for (int i = 0; i < 55; i++) begin
				if ($urandom_range(0, 6) == 0) begin
					send_region(rand64(), rand64(), $urandom, 1'($urandom_range(0, 1)));
				end else begin
					len = unit * $urandom_range(0, 5);
					if ($urandom_range(0, 1) == 1)
						len = len + (rand64() & (unit - 1));
					send_region(cur, len, $urandom, nm);
					nm = ($urandom_range(0, 11) == 0);
					if (nm)
						cur = unit * $urandom_range(0, 3);
					else if ($urandom_range(0, 2) == 0)
						cur = cur + len + unit * $urandom_range(0, 2);
					else
						cur = cur + len;
				end
			end
		end

		region_valid <= 1'b0;
		@(posedge clk);
		while (pieces_due != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (miss_count == 0 && pieces_due == 0)
			$display("[memory_map_kernel_carve] OK");
		else
			$display("[memory_map_kernel_carve] ERROR");
		$finish;
	end

endmodule

[sim.f]
src/mmkc_pkg.sv
src/memory_map_kernel_carve.sv
bench/mmkc_checker.sv
bench/tb_memory_map_kernel_carve.sv
